[hw/rtl/pswe_pkg.sv]
// Shared types and constants for the pulse source waveform evaluator.
`default_nettype none
package pswe_pkg;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned LEVEL_W = 16;
    localparam int unsigned CIDX_W  = 8;
    // Quotient of a ramp always fits in the level magnitude plus one bit.
    localparam int unsigned QUO_W   = LEVEL_W + 1;
    localparam int unsigned PROD_W  = LEVEL_W + TIME_W;

    typedef logic [TIME_W-1:0]         t_time;
    typedef logic signed [LEVEL_W-1:0] t_level;

    localparam logic [CIDX_W-1:0] REG_LOW_LEVEL   = 8'd0;
    localparam logic [CIDX_W-1:0] REG_HIGH_LEVEL  = 8'd1;
    localparam logic [CIDX_W-1:0] REG_DELAY_TIME  = 8'd2;
    localparam logic [CIDX_W-1:0] REG_RISE_TIME   = 8'd3;
    localparam logic [CIDX_W-1:0] REG_FALL_TIME   = 8'd4;
    localparam logic [CIDX_W-1:0] REG_PULSE_WIDTH = 8'd5;
    localparam logic [CIDX_W-1:0] REG_PERIOD_TIME = 8'd6;
    localparam logic [CIDX_W-1:0] REG_STOP_TIME   = 8'd7;
endpackage
`default_nettype wire

[hw/rtl/pulse_source_waveform_eval_core.sv]
// Pipelined trapezoidal pulse source: modulo, segment select, multiply, divide.
//
//  channel  | ports                                   | flow
//  ---------+-----------------------------------------+------------------------
//  sample   | i_start, o_busy, i_sample_time          | in, taken when !o_busy
//  result   | o_valid, o_level, o_out_of_range        | out, one-cycle strobe
//  config   | i_cfg_valid, o_cfg_ready, i_cfg_index,  | in, valid/ready write
//           | i_cfg_data                              |
//
// One word enters per cycle; o_busy is always low.
// Registers in order: entry, 32 modulo steps, segment, multiply, divide load,
// 17 divide steps, output register. Depth is set by the bit-serial modulo and divide chains.
// Reset is synchronous; it clears valid bits and loads register defaults.
// The receiver cannot stall, so the pipeline never holds.
`default_nettype none
module pulse_source_waveform_eval_core #(
    parameter int unsigned STEP_TIME = 1
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_start,
    output logic                               o_busy,
    input  wire  [pswe_pkg::TIME_W-1:0]        i_sample_time,
    output logic                               o_valid,
    output logic signed [pswe_pkg::LEVEL_W-1:0] o_level,
    output logic                               o_out_of_range,
    input  wire                                i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire  [pswe_pkg::CIDX_W-1:0]        i_cfg_index,
    input  wire  [pswe_pkg::TIME_W-1:0]        i_cfg_data
);
    localparam int unsigned TW = pswe_pkg::TIME_W;
    localparam int unsigned LW = pswe_pkg::LEVEL_W;
    localparam int unsigned QW = pswe_pkg::QUO_W;
    localparam int unsigned PW = pswe_pkg::PROD_W;

    // configuration
    pswe_pkg::t_level r_low, r_high;
    pswe_pkg::t_time  r_delay, r_rise, r_fall, r_width, r_period, r_stop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low    <= '0;
            r_high   <= '0;
            r_delay  <= '0;
            r_rise   <= '0;
            r_fall   <= '0;
            r_width  <= '0;
            r_period <= '0;
            r_stop   <= '1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                pswe_pkg::REG_LOW_LEVEL:   r_low    <= i_cfg_data[LW-1:0];
                pswe_pkg::REG_HIGH_LEVEL:  r_high   <= i_cfg_data[LW-1:0];
                pswe_pkg::REG_DELAY_TIME:  r_delay  <= i_cfg_data;
                pswe_pkg::REG_RISE_TIME:   r_rise   <= i_cfg_data;
                pswe_pkg::REG_FALL_TIME:   r_fall   <= i_cfg_data;
                pswe_pkg::REG_PULSE_WIDTH: r_width  <= i_cfg_data;
                pswe_pkg::REG_PERIOD_TIME: r_period <= i_cfg_data;
                pswe_pkg::REG_STOP_TIME:   r_stop   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_busy      = 1'b0;

    localparam pswe_pkg::t_time STEP = TW'(STEP_TIME);
    pswe_pkg::t_time tr_eff, tf_eff, pw_eff, per_eff;
    assign tr_eff  = (r_rise   != '0) ? r_rise   : STEP;
    assign tf_eff  = (r_fall   != '0) ? r_fall   : STEP;
    assign pw_eff  = (r_width  != '0) ? r_width  : STEP;
    // a zero period here only happens with stop 0, so any in-range time is 0 and passes as is
    assign per_eff = (r_period != '0) ? r_period : r_stop;

    // modulo pipeline, one remainder bit per stage
    logic          r_m_valid [0:TW];
    logic          r_m_oor   [0:TW];
    pswe_pkg::t_time r_m_rem [0:TW];
    pswe_pkg::t_time r_m_t   [0:TW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid[0] <= 1'b0;
        end else begin
            r_m_valid[0] <= i_start;
        end
        r_m_oor[0] <= i_sample_time > r_stop;
        r_m_rem[0] <= '0;
        r_m_t[0]   <= i_sample_time;
    end

    for (genvar k = 0; k < TW; k++) begin : g_mod
        logic [TW:0] n_x;
        assign n_x = {r_m_rem[k], r_m_t[k][TW-1]};
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_m_valid[k+1] <= 1'b0;
            end else begin
                r_m_valid[k+1] <= r_m_valid[k];
            end
            r_m_oor[k+1] <= r_m_oor[k];
            r_m_t[k+1]   <= {r_m_t[k][TW-2:0], 1'b0};
            if (n_x >= {1'b0, per_eff}) begin
                r_m_rem[k+1] <= TW'(n_x - {1'b0, per_eff});
            end else begin
                r_m_rem[k+1] <= n_x[TW-1:0];
            end
        end
    end

    // segment select
    logic [TW+1:0] n_e_delay, n_e_rise, n_e_high, n_e_fall, n_t;
    logic signed [LW:0] n_delta;
    assign n_t       = {2'b00, r_m_rem[TW]};
    assign n_e_delay = {2'b00, r_delay};
    assign n_e_rise  = n_e_delay + {2'b00, tr_eff};
    assign n_e_high  = n_e_rise + {2'b00, pw_eff};
    assign n_e_fall  = n_e_high + {2'b00, tf_eff};
    assign n_delta   = {r_high[LW-1], r_high} - {r_low[LW-1], r_low};

    logic               r_s_valid, r_s_oor, r_s_flat, r_s_fall, r_s_neg;
    pswe_pkg::t_level   r_s_from;
    logic [LW-1:0]      r_s_mag;
    pswe_pkg::t_time    r_s_elapsed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid <= 1'b0;
        end else begin
            r_s_valid <= r_m_valid[TW];
        end
        r_s_oor <= r_m_oor[TW];
        r_s_mag <= n_delta[LW] ? LW'(-n_delta) : n_delta[LW-1:0];
        if (n_t <= n_e_delay) begin
            r_s_flat <= 1'b1; r_s_fall <= 1'b0; r_s_neg <= 1'b0;
            r_s_from <= r_low; r_s_elapsed <= '0;
        end else if (n_t <= n_e_rise) begin
            r_s_flat <= 1'b0; r_s_fall <= 1'b0; r_s_neg <= n_delta[LW];
            r_s_from <= r_low; r_s_elapsed <= TW'(n_t - n_e_delay);
        end else if (n_t <= n_e_high) begin
            r_s_flat <= 1'b1; r_s_fall <= 1'b0; r_s_neg <= 1'b0;
            r_s_from <= r_high; r_s_elapsed <= '0;
        end else if (n_t <= n_e_fall) begin
            r_s_flat <= 1'b0; r_s_fall <= 1'b1; r_s_neg <= ~n_delta[LW];
            r_s_from <= r_high; r_s_elapsed <= TW'(n_t - n_e_high);
        end else begin
            r_s_flat <= 1'b1; r_s_fall <= 1'b0; r_s_neg <= 1'b0;
            r_s_from <= r_low; r_s_elapsed <= '0;
        end
    end

    // multiply: magnitude of delta times elapsed
    logic             r_p_valid, r_p_oor, r_p_flat, r_p_fall, r_p_neg;
    pswe_pkg::t_level r_p_from;
    logic [PW-1:0]    r_p_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else begin
            r_p_valid <= r_s_valid;
        end
        r_p_oor  <= r_s_oor;
        r_p_flat <= r_s_flat;
        r_p_fall <= r_s_fall;
        r_p_neg  <= r_s_neg;
        r_p_from <= r_s_from;
        r_p_prod <= {{TW{1'b0}}, r_s_mag} * {{LW{1'b0}}, r_s_elapsed};
    end

    // divide: quotient below 2**QW, so the top bits start as the remainder
    logic             r_d_valid [0:QW];
    logic             r_d_oor   [0:QW];
    logic             r_d_flat  [0:QW];
    logic             r_d_fall  [0:QW];
    logic             r_d_neg   [0:QW];
    pswe_pkg::t_level r_d_from  [0:QW];
    pswe_pkg::t_time  r_d_rem   [0:QW];
    logic [QW-1:0]    r_d_dd    [0:QW];
    logic [QW-1:0]    r_d_q     [0:QW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid[0] <= 1'b0;
        end else begin
            r_d_valid[0] <= r_p_valid;
        end
        r_d_oor[0]  <= r_p_oor;
        r_d_flat[0] <= r_p_flat;
        r_d_fall[0] <= r_p_fall;
        r_d_neg[0]  <= r_p_neg;
        r_d_from[0] <= r_p_from;
        r_d_rem[0]  <= TW'(r_p_prod[PW-1:QW]);
        r_d_dd[0]   <= r_p_prod[QW-1:0];
        r_d_q[0]    <= '0;
    end

    for (genvar k = 0; k < QW; k++) begin : g_div
        logic [TW:0]     n_x;
        pswe_pkg::t_time n_dur;
        assign n_dur = r_d_fall[k] ? tf_eff : tr_eff;
        assign n_x   = {r_d_rem[k], r_d_dd[k][QW-1]};
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d_valid[k+1] <= 1'b0;
            end else begin
                r_d_valid[k+1] <= r_d_valid[k];
            end
            r_d_oor[k+1]  <= r_d_oor[k];
            r_d_flat[k+1] <= r_d_flat[k];
            r_d_fall[k+1] <= r_d_fall[k];
            r_d_neg[k+1]  <= r_d_neg[k];
            r_d_from[k+1] <= r_d_from[k];
            r_d_dd[k+1]   <= {r_d_dd[k][QW-2:0], 1'b0};
            if (n_x >= {1'b0, n_dur}) begin
                r_d_rem[k+1] <= TW'(n_x - {1'b0, n_dur});
                r_d_q[k+1]   <= {r_d_q[k][QW-2:0], 1'b1};
            end else begin
                r_d_rem[k+1] <= n_x[TW-1:0];
                r_d_q[k+1]   <= {r_d_q[k][QW-2:0], 1'b0};
            end
        end
    end

    // output
    logic [LW-1:0] n_step, n_sum;
    assign n_step = r_d_neg[QW] ? LW'(-r_d_q[QW]) : r_d_q[QW][LW-1:0];
    assign n_sum  = r_d_from[QW] + n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_d_valid[QW];
        end
        o_out_of_range <= r_d_oor[QW];
        if (r_d_oor[QW]) begin
            o_level <= '0;
        end else if (r_d_flat[QW]) begin
            o_level <= r_d_from[QW];
        end else begin
            o_level <= n_sum;
        end
    end

    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_of_range |-> o_level == '0)
        else $error("out of range word with nonzero level");

    a_out_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_d_valid[QW]))
        else $error("result strobe without a word in the last divide stage");

    a_flat_quotient: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_d_valid[QW] && r_d_flat[QW] |-> r_d_q[QW] == '0)
        else $error("flat segment produced a nonzero quotient");

    a_ramp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_d_valid[QW] && !r_d_flat[QW] && !i_cfg_valid && $past(!i_cfg_valid)
        |-> r_d_q[QW] <= QW'(r_d_fall[QW] ? tf_eff : tr_eff) || r_d_q[QW][QW-1] == 1'b0)
        else $error("ramp quotient out of range");
endmodule
`default_nettype wire

[tb/sv/tb.sv]
// Testbench for the pulse source waveform evaluator: scoreboard, drivers, random regression.
`timescale 1ns / 1ps
module tb;
    localparam int unsigned STEP = 1;
    localparam int unsigned DRAIN_CYCLES = 60;
    localparam int unsigned MAX_CYCLES = 400000;
    localparam logic [pswe_pkg::CIDX_W-1:0] REG_OFF_LIST = 8'd8;

    typedef struct {
        pswe_pkg::t_level level;
        logic             out_of_range;
    } t_level_word;

    class level_scoreboard;
        pswe_pkg::t_level lo_lvl, hi_lvl;
        pswe_pkg::t_time  delay_t, rise_t, fall_t, width_t, period_t, stop_t;
        t_level_word expected_levels[$];
        int errors;

        function new();
            errors = 0;
            reset_regs();
        endfunction

        function void reset_regs();
            lo_lvl = '0; hi_lvl = '0;
            delay_t = '0; rise_t = '0; fall_t = '0; width_t = '0; period_t = '0;
            stop_t = '1;
        endfunction

        function void write_reg(logic [pswe_pkg::CIDX_W-1:0] idx, pswe_pkg::t_time data);
            case (idx)
                pswe_pkg::REG_LOW_LEVEL:   lo_lvl   = data[pswe_pkg::LEVEL_W-1:0];
                pswe_pkg::REG_HIGH_LEVEL:  hi_lvl   = data[pswe_pkg::LEVEL_W-1:0];
                pswe_pkg::REG_DELAY_TIME:  delay_t  = data;
                pswe_pkg::REG_RISE_TIME:   rise_t   = data;
                pswe_pkg::REG_FALL_TIME:   fall_t   = data;
                pswe_pkg::REG_PULSE_WIDTH: width_t  = data;
                pswe_pkg::REG_PERIOD_TIME: period_t = data;
                pswe_pkg::REG_STOP_TIME:   stop_t   = data;
                default: ;
            endcase
        endfunction

        function longint ramp_level(pswe_pkg::t_level from_l, pswe_pkg::t_level to_l,
                                    longint el, longint dur);
            longint delta;
            delta = longint'(to_l) - longint'(from_l);
            return longint'(from_l) + (delta * el) / dur;
        endfunction

        // segment ends, widened so long segments never wrap
        function longint unsigned rise_end();
            return longint'(delay_t) + (rise_t != 0 ? longint'(rise_t) : STEP);
        endfunction
        function longint unsigned high_end();
            return rise_end() + (width_t != 0 ? longint'(width_t) : STEP);
        endfunction
        function longint unsigned fall_end();
            return high_end() + (fall_t != 0 ? longint'(fall_t) : STEP);
        endfunction

        function void note_sample(pswe_pkg::t_time t);
            t_level_word w;
            longint unsigned tt, per, tr, tf;
            longint lv;
            if (t > stop_t) begin
                w.level = '0;
                w.out_of_range = 1'b1;
            end else begin
                tr = rise_t != 0 ? rise_t : STEP;
                tf = fall_t != 0 ? fall_t : STEP;
                per = period_t != 0 ? period_t : stop_t;
                tt = t;
                if (per != 0) tt = tt % per;
                if (tt <= delay_t)
                    lv = lo_lvl;
                else if (tt <= rise_end())
                    lv = ramp_level(lo_lvl, hi_lvl, tt - delay_t, tr);
                else if (tt <= high_end())
                    lv = hi_lvl;
                else if (tt <= fall_end())
                    lv = ramp_level(hi_lvl, lo_lvl, tt - high_end(), tf);
                else
                    lv = lo_lvl;
                w.level = lv[pswe_pkg::LEVEL_W-1:0];
                w.out_of_range = 1'b0;
            end
            expected_levels.push_back(w);
        endfunction

        function void check_result(pswe_pkg::t_level level, logic oor);
            t_level_word w;
            if (expected_levels.size() == 0) begin
                $error("unexpected result word: level %0d out_of_range %0b", level, oor);
                errors++;
                return;
            end
            w = expected_levels.pop_front();
            if (level !== w.level) begin
                $error("level: expected %0d, actual %0d", w.level, level);
                errors++;
            end
            if (oor !== w.out_of_range) begin
                $error("out_of_range: expected %0b, actual %0b", w.out_of_range, oor);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_start = 1'b0;
    pswe_pkg::t_time i_sample_time = '0;
    logic i_cfg_valid = 1'b0;
    logic [pswe_pkg::CIDX_W-1:0] i_cfg_index = '0;
    pswe_pkg::t_time i_cfg_data = '0;
    logic o_busy, o_valid, o_out_of_range, o_cfg_ready;
    pswe_pkg::t_level o_level;

    level_scoreboard sb = new();
    int unsigned cycles = 0;
    bit no_idle = 1'b0;

    always #10 i_clk = ~i_clk;

    pulse_source_waveform_eval_core #(.STEP_TIME(STEP)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_sample_time(i_sample_time), .o_valid(o_valid), .o_level(o_level),
        .o_out_of_range(o_out_of_range), .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= MAX_CYCLES) begin
            $display("pulse_source_waveform_eval_core regression: fail");
            $finish;
        end
        if (i_rst_n && o_valid) sb.check_result(o_level, o_out_of_range);
    end

    task automatic write_reg(logic [pswe_pkg::CIDX_W-1:0] idx, pswe_pkg::t_time data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_regs(int lo, int hi, pswe_pkg::t_time dly, pswe_pkg::t_time rise,
                            pswe_pkg::t_time fall, pswe_pkg::t_time width,
                            pswe_pkg::t_time per, pswe_pkg::t_time stop);
        // upper data bits are junk for the level registers
        write_reg(pswe_pkg::REG_LOW_LEVEL, {16'($urandom_range(0, 65535)), lo[15:0]});
        write_reg(pswe_pkg::REG_HIGH_LEVEL, {16'($urandom_range(0, 65535)), hi[15:0]});
        write_reg(pswe_pkg::REG_DELAY_TIME, dly);
        write_reg(pswe_pkg::REG_RISE_TIME, rise);
        write_reg(pswe_pkg::REG_FALL_TIME, fall);
        write_reg(pswe_pkg::REG_PULSE_WIDTH, width);
        write_reg(pswe_pkg::REG_PERIOD_TIME, per);
        write_reg(pswe_pkg::REG_STOP_TIME, stop);
        write_reg(pswe_pkg::CIDX_W'(REG_OFF_LIST + $urandom_range(0, 247)), $urandom);
    endtask

    task automatic send_sample(pswe_pkg::t_time t);
        // each draw under 21 of 100 leaves the inputs idle once more, so about a fifth of the cycles carry no word
        while (!no_idle && $urandom_range(0, 99) < 21) begin
            @(negedge i_clk);
            i_start <= 1'b0;
            i_sample_time <= $urandom;
        end
        @(negedge i_clk);
        i_start <= 1'b1;
        i_sample_time <= t;
        do @(posedge i_clk); while (o_busy);
        sb.note_sample(t);
    endtask

    // pipeline has to be empty before any register moves
    task automatic drain();
        @(negedge i_clk);
        i_start <= 1'b0;
        while (sb.expected_levels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic pswe_pkg::t_time rand_span();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 2) return '0;
        if (r < 7) return $urandom_range(1, 20);
        return $urandom;
    endfunction

    function automatic pswe_pkg::t_time pick_time();
        int unsigned r;
        longint unsigned b, span;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            span = sb.fall_end() + 20;
            if (span > 1000) span = 1000;
            b = $urandom_range(0, int'(span));
            if (r < 30 && sb.period_t != 0 && sb.period_t < 5000)
                b = b + longint'(sb.period_t) * $urandom_range(0, 3);
        end else if (r < 80) begin
            case ($urandom_range(0, 5))
                0: b = sb.delay_t;
                1: b = sb.rise_end();
                2: b = sb.high_end();
                3: b = sb.fall_end();
                4: b = sb.stop_t;
                default: b = sb.period_t;
            endcase
            b = b + $urandom_range(0, 2) - 1;
        end else begin
            b = $urandom;
        end
        return b[pswe_pkg::TIME_W-1:0];
    endfunction

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // defaults: flat zero, no stop
        send_sample('0);
        send_sample('1);
        send_sample(32'h8000_0000);
        drain();

        // full-scale rising pulse, edges of every segment
        set_regs(-32768, 32767, 10, 7, 13, 5, 60, 1000);
        send_sample(10); send_sample(11); send_sample(16); send_sample(17);
        send_sample(18); send_sample(22); send_sample(23); send_sample(29);
        send_sample(35); send_sample(36); send_sample(70); send_sample(1000);
        send_sample(1001);
        drain();

        // inverted levels, zero ramp/width registers, zero period uses stop
        set_regs(32767, -32768, 3, 0, 0, 0, 0, 500);
        send_sample(3); send_sample(4); send_sample(5); send_sample(6);
        send_sample(503); send_sample(500);
        drain();

        // zero period and zero stop: no reduction
        set_regs(-5, 9, 0, 2, 2, 2, 0, 0);
        send_sample(0); send_sample(1); send_sample('1);
        drain();

        // segment sums beyond 32 bits
        set_regs(-1000, 1000, 32'hFFFF_FFF0, '1, '1, '1, 0, '1);
        send_sample(32'hFFFF_FFF0); send_sample(32'hFFFF_FFF1); send_sample('1);
        drain();

        for (int ph = 0; ph < 10; ph++) begin
            pswe_pkg::t_time stop;
            int unsigned r;
            r = $urandom_range(0, 3);
            stop = r < 2 ? pswe_pkg::t_time'($urandom_range(50, 2000))
                         : (r == 2 ? '1 : $urandom);
            set_regs($urandom_range(0, 65535), $urandom_range(0, 65535), rand_span(),
                     rand_span(), rand_span(), rand_span(),
                     $urandom_range(0, 9) < 3 ? pswe_pkg::t_time'(0)
                        : ($urandom_range(0, 9) < 8
                           ? pswe_pkg::t_time'($urandom_range(1, 150))
                           : pswe_pkg::t_time'($urandom)),
                     stop);
            no_idle = (ph == 4);
            repeat (170) send_sample(pick_time());
            no_idle = 1'b0;
            drain();
        end

        if (sb.errors == 0 && sb.expected_levels.size() == 0) begin
            $display("pulse_source_waveform_eval_core regression: pass");
        end else begin
            $display("pulse_source_waveform_eval_core regression: fail");
        end
        $finish;
    end
endmodule
